[rtl/core/shm_pkg.sv]
// ----------------------------------------------------------------------------
// shm_pkg: shared types and constants of the sensor health monitor
// Field widths, event and register codes, reset values of the settings and
// the stale threshold helper.
// ----------------------------------------------------------------------------
package shm_pkg;

    localparam int unsigned ACTION_W      = 2;
    localparam int unsigned SENSOR_ID_W   = 4;
    localparam int unsigned TIME_W        = 32;
    localparam int unsigned COUNT_W       = 32;
    localparam int unsigned STREAK_LIM_W  = 8;
    localparam int unsigned STALE_MS_W    = 16;
    localparam int unsigned CFG_INDEX_W   = 2;
    localparam int unsigned CFG_DATA_W    = 16;

    // Largest threshold: 65535 ms * 1000 + 999 us still fits 26 bits.
    localparam int unsigned STALE_THR_W   = 26;
    localparam int unsigned US_PER_MS     = 1000;

    localparam int unsigned NUM_SENSORS_DEF = 16;

    localparam logic [STREAK_LIM_W-1:0] FAIL_STREAK_LIMIT_RST  = STREAK_LIM_W'(5);
    localparam logic [STALE_MS_W-1:0]   STALE_LIMIT_MS_RST     = STALE_MS_W'(500);
    localparam logic                    STALE_CHECK_ENABLE_RST = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SUCCESS = 2'd0,
        ACT_FAILURE = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_CHECK   = 2'd3
    } t_action;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FAIL_STREAK_LIMIT  = 2'd0,
        CFG_STALE_LIMIT_MS     = 2'd1,
        CFG_STALE_CHECK_ENABLE = 2'd2
    } t_cfg_reg;

    // floor(elapsed / 1000) > ms  <=>  elapsed > ms * 1000 + 999
    function automatic logic [STALE_THR_W-1:0] stale_thr_us(
        input logic [STALE_MS_W-1:0] ms
    );
        return STALE_THR_W'(ms) * STALE_THR_W'(US_PER_MS)
             + STALE_THR_W'(US_PER_MS - 1);
    endfunction

endpackage

[rtl/core/sensor_health_monitor_core.sv]
// ----------------------------------------------------------------------------
// sensor_health_monitor_core: per-sensor health table
// Tracks read, failure and streak counts and the last success time of each
// sensor and reports the sensor's health after every event.
// ----------------------------------------------------------------------------
// An event enters an input register; once the output register is free or
// being emptied, the sensor's table entry is read, updated, written back and
// the health result is placed in the output register. Events are taken one
// per cycle while the result side does not stall; back-to-back events
// on the same sensor see each other's updates because the table write lands
// at the same edge that frees the input register. Stalls on the result side
// back up through the input register to o_in_stall. The table is cleared by
// reset. The stale limit is kept in microseconds (limit * 1000 + 999),
// computed when the register is written. Configuration writes are always
// taken (o_cfg_ready is tied high); writes to an unused index are ignored.
// Sensor ids at or above NUM_SENSORS leave the table alone and report
// unhealthy with zero counts.
module sensor_health_monitor_core #(
    parameter int unsigned NUM_SENSORS = shm_pkg::NUM_SENSORS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [shm_pkg::ACTION_W-1:0]      i_action,
    input  logic [shm_pkg::SENSOR_ID_W-1:0]   i_sensor_id,
    input  logic [shm_pkg::TIME_W-1:0]        i_now_us,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_healthy,
    output logic [shm_pkg::COUNT_W-1:0]       o_total_reads,
    output logic [shm_pkg::COUNT_W-1:0]       o_total_failures,
    output logic [shm_pkg::COUNT_W-1:0]       o_fail_streak,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [shm_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [shm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import shm_pkg::*;

    localparam int unsigned IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    // ---------------- configuration ----------------
    logic [STREAK_LIM_W-1:0] r_fail_limit;
    logic [STALE_THR_W-1:0]  r_stale_thr;
    logic                    r_stale_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_limit <= FAIL_STREAK_LIMIT_RST;
            r_stale_thr  <= stale_thr_us(STALE_LIMIT_MS_RST);
            r_stale_en   <= STALE_CHECK_ENABLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FAIL_STREAK_LIMIT: begin
                    r_fail_limit <= i_cfg_data[STREAK_LIM_W-1:0];
                end
                CFG_STALE_LIMIT_MS: begin
                    r_stale_thr <= stale_thr_us(i_cfg_data[STALE_MS_W-1:0]);
                end
                CFG_STALE_CHECK_ENABLE: begin
                    r_stale_en <= i_cfg_data[0];
                end
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                   r_in_valid;
    t_action                r_action;
    logic [SENSOR_ID_W-1:0] r_id;
    logic [TIME_W-1:0]      r_now;

    logic r_out_valid;
    logic adv;

    // The event in the input register moves on whenever the output register
    // is free or being emptied this cycle.
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action <= t_action'(i_action);
            r_id     <= i_sensor_id;
            r_now    <= i_now_us;
        end
    end

    // ---------------- table read-modify-write ----------------
    logic [COUNT_W-1:0] r_reads  [NUM_SENSORS];
    logic [COUNT_W-1:0] r_fails  [NUM_SENSORS];
    logic [COUNT_W-1:0] r_streak [NUM_SENSORS];
    logic [TIME_W-1:0]  r_last   [NUM_SENSORS];

    logic               in_range;
    logic [IDX_W-1:0]   idx;
    logic [COUNT_W-1:0] cur_reads, cur_fails, cur_streak;
    logic [TIME_W-1:0]  cur_last;
    logic [COUNT_W-1:0] n_reads, n_fails, n_streak;
    logic [TIME_W-1:0]  n_last;
    logic [TIME_W-1:0]  elapsed;
    logic               stale;
    logic               n_healthy;
    logic               do_write;

    assign in_range = 32'(r_id) < NUM_SENSORS;
    assign idx      = IDX_W'(r_id);

    always_comb begin
        if (in_range) begin
            cur_reads  = r_reads[idx];
            cur_fails  = r_fails[idx];
            cur_streak = r_streak[idx];
            cur_last   = r_last[idx];
        end else begin
            cur_reads  = '0;
            cur_fails  = '0;
            cur_streak = '0;
            cur_last   = '0;
        end
    end

    always_comb begin
        n_reads  = cur_reads;
        n_fails  = cur_fails;
        n_streak = cur_streak;
        n_last   = cur_last;
        unique case (r_action)
            ACT_SUCCESS: begin
                n_reads  = cur_reads + COUNT_W'(1);
                n_streak = '0;
                n_last   = r_now;
            end
            ACT_FAILURE: begin
                n_reads = cur_reads + COUNT_W'(1);
                n_fails = cur_fails + COUNT_W'(1);
                // streak saturates at all ones
                if (cur_streak != '1) begin
                    n_streak = cur_streak + COUNT_W'(1);
                end
            end
            ACT_CLEAR: begin
                n_reads  = '0;
                n_fails  = '0;
                n_streak = '0;
                n_last   = '0;
            end
            ACT_CHECK: begin
                // leave the entry as it is
            end
        endcase
    end

    assign elapsed   = r_now - n_last;
    assign stale     = r_stale_en && (elapsed > TIME_W'(r_stale_thr));
    assign n_healthy = in_range && (n_reads != '0)
                    && (n_streak < COUNT_W'(r_fail_limit)) && !stale;

    assign do_write = r_in_valid && adv && in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_reads[i]  <= '0;
                r_fails[i]  <= '0;
                r_streak[i] <= '0;
                r_last[i]   <= '0;
            end
        end else if (do_write) begin
            r_reads[idx]  <= n_reads;
            r_fails[idx]  <= n_fails;
            r_streak[idx] <= n_streak;
            r_last[idx]   <= n_last;
        end
    end

    // ---------------- output register ----------------
    logic               r_healthy;
    logic [COUNT_W-1:0] r_out_reads, r_out_fails, r_out_streak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    // An id outside the table reports zero counts whatever the action.
    always_ff @(posedge i_clk) begin
        if (r_in_valid && adv) begin
            r_healthy    <= n_healthy;
            r_out_reads  <= in_range ? n_reads  : '0;
            r_out_fails  <= in_range ? n_fails  : '0;
            r_out_streak <= in_range ? n_streak : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_healthy        = r_healthy;
    assign o_total_reads    = r_out_reads;
    assign o_total_failures = r_out_fails;
    assign o_fail_streak    = r_out_streak;

    // ---------------- assertions ----------------
    a_healthy_has_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_healthy |-> (o_total_reads != '0))
        else $error("healthy result with zero reads");

    a_healthy_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_healthy |-> (o_fail_streak < COUNT_W'(r_fail_limit)))
        else $error("healthy result with streak at limit");

    a_success_clears_streak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && adv && (r_action == ACT_SUCCESS)
        |=> o_out_valid && (o_fail_streak == '0))
        else $error("success did not clear the streak");

    a_clear_reports_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && adv && (r_action == ACT_CLEAR)
        |=> o_out_valid && !o_healthy && (o_total_reads == '0)
            && (o_total_failures == '0))
        else $error("cleared entry reported nonzero");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_id) && $stable(r_now))
        else $error("input register lost a stalled item");

endmodule

[bench/sensor_health_monitor_core_test.sv]
// ----------------------------------------------------------------------------
// sensor_health_monitor_core_test: self-checking bench of the health table
// Drives health events and register writes through the core's handshakes,
// predicts every sensor entry and health result in a scoreboard, and checks
// each result in order under random idling on both sides.
// ----------------------------------------------------------------------------
module sensor_health_monitor_core_test;
    import shm_pkg::*;

    localparam int N_SENSORS       = NUM_SENSORS_DEF;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int STALL_LIMIT     = 2000;
    localparam int REPORT_LIMIT    = 10;

    // Index with no register behind it; writes to it must be dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // Expected contents of one result item.
    typedef struct packed {
        logic               healthy;
        logic [COUNT_W-1:0] reads;
        logic [COUNT_W-1:0] failures;
        logic [COUNT_W-1:0] streak;
    } health_rec_t;

    // Mirror of the health table and settings, plus the results still owed.
    class health_scoreboard;
        logic [COUNT_W-1:0]      reads    [N_SENSORS];
        logic [COUNT_W-1:0]      failures [N_SENSORS];
        logic [COUNT_W-1:0]      streak   [N_SENSORS];
        logic [TIME_W-1:0]       last_ok  [N_SENSORS];
        logic [STREAK_LIM_W-1:0] streak_limit;
        logic [STALE_MS_W-1:0]   stale_ms;
        logic                    stale_on;
        health_rec_t             awaited[$];
        int                      mismatches;

        function new();
            for (int s = 0; s < N_SENSORS; s++) begin
                reads[s]    = '0;
                failures[s] = '0;
                streak[s]   = '0;
                last_ok[s]  = '0;
            end
            streak_limit = FAIL_STREAK_LIMIT_RST;
            stale_ms     = STALE_LIMIT_MS_RST;
            stale_on     = STALE_CHECK_ENABLE_RST;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FAIL_STREAK_LIMIT:  streak_limit = data[STREAK_LIM_W-1:0];
                CFG_STALE_LIMIT_MS:     stale_ms     = data[STALE_MS_W-1:0];
                CFG_STALE_CHECK_ENABLE: stale_on     = data[0];
                default: ;
            endcase
        endfunction

        function logic slot_ok(int s, logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] elapsed;
            elapsed = now - last_ok[s];
            if (reads[s] == '0)
                return 1'b0;
            if (streak[s] >= COUNT_W'(streak_limit))
                return 1'b0;
            if (stale_on && (elapsed / US_PER_MS) > TIME_W'(stale_ms))
                return 1'b0;
            return 1'b1;
        endfunction

        function void note_event(t_action act, logic [SENSOR_ID_W-1:0] id,
                                 logic [TIME_W-1:0] now);
            health_rec_t rec;
            int          s;
            s   = int'(id);
            rec = '0;
            if (s < N_SENSORS) begin
                case (act)
                    ACT_SUCCESS: begin
                        reads[s]   = reads[s] + 1'b1;
                        streak[s]  = '0;
                        last_ok[s] = now;
                    end
                    ACT_FAILURE: begin
                        reads[s]    = reads[s] + 1'b1;
                        failures[s] = failures[s] + 1'b1;
                        if (streak[s] != '1)
                            streak[s] = streak[s] + 1'b1;
                    end
                    ACT_CLEAR: begin
                        reads[s]    = '0;
                        failures[s] = '0;
                        streak[s]   = '0;
                        last_ok[s]  = '0;
                    end
                    default: ;
                endcase
                rec.healthy  = slot_ok(s, now);
                rec.reads    = reads[s];
                rec.failures = failures[s];
                rec.streak   = streak[s];
            end
            awaited.push_back(rec);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_result(logic healthy, logic [COUNT_W-1:0] reads_got,
                                   logic [COUNT_W-1:0] fails_got,
                                   logic [COUNT_W-1:0] streak_got);
            health_rec_t want;
            if (awaited.size() == 0) begin
                flag($sformatf("unexpected result: healthy %0b reads %0h failures %0h streak %0h",
                               healthy, reads_got, fails_got, streak_got));
                return;
            end
            want = awaited.pop_front();
            if (healthy !== want.healthy)
                flag($sformatf("healthy: expected %0b, got %0b", want.healthy, healthy));
            if (reads_got !== want.reads)
                flag($sformatf("total_reads: expected %0h, got %0h", want.reads, reads_got));
            if (fails_got !== want.failures)
                flag($sformatf("total_failures: expected %0h, got %0h",
                               want.failures, fails_got));
            if (streak_got !== want.streak)
                flag($sformatf("fail_streak: expected %0h, got %0h", want.streak, streak_got));
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [ACTION_W-1:0]    i_action;
    logic [SENSOR_ID_W-1:0] i_sensor_id;
    logic [TIME_W-1:0]      i_now_us;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_healthy;
    logic [COUNT_W-1:0]     o_total_reads;
    logic [COUNT_W-1:0]     o_total_failures;
    logic [COUNT_W-1:0]     o_fail_streak;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    health_scoreboard sb = new();

    // Stimulus knobs shared by the driving tasks.
    bit                     calm;       // last part of the run: no idling at all
    int unsigned            gap_odds;   // 1 in gap_odds items is preceded by a gap, 0: none
    int unsigned            fail_run;   // failures still to send in the current run
    logic [SENSOR_ID_W-1:0] run_id;
    bit                     long_done;  // one long run per phase when the limit is high
    logic [TIME_W-1:0]      t_base;     // running time base of the random events

    sensor_health_monitor_core #(
        .NUM_SENSORS (N_SENSORS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_sensor_id      (i_sensor_id),
        .i_now_us         (i_now_us),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_healthy        (o_healthy),
        .o_total_reads    (o_total_reads),
        .o_total_failures (o_total_failures),
        .o_fail_streak    (o_fail_streak),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Monitor: note every accepted event before checking the result of the
    // same edge, so the queue always holds the expectation being matched.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                sb.note_event(t_action'(i_action), i_sensor_id, i_now_us);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_healthy, o_total_reads, o_total_failures, o_fail_streak);
        end
    end

    // Watchdog: end the run when no handshake completes for too long.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && !o_in_stall)
                    || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side: alternate free stretches (sometimes long) with random stall
    // bursts; hold stall low once the run turns calm.
    initial begin
        int unsigned free_len;
        i_out_stall = 1'b0;
        forever begin
            free_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 12);
            i_out_stall = 1'b0;
            repeat (free_len + 1) @(negedge i_clk);
            if (!calm) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
        end
    end

    // Present one event at a falling edge, hold it until taken, and return
    // at the next falling edge with valid still high.
    task automatic push_event(t_action act, logic [SENSOR_ID_W-1:0] id,
                              logic [TIME_W-1:0] now);
        if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_action    = act;
        i_sensor_id = id;
        i_now_us    = now;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Write all three registers; the unused upper data bits carry noise.
    task automatic apply_settings(logic [STREAK_LIM_W-1:0] lim, logic [STALE_MS_W-1:0] ms,
                                  logic en);
        cfg_write(CFG_FAIL_STREAK_LIMIT, {8'($urandom), lim});
        cfg_write(CFG_STALE_LIMIT_MS, ms);
        cfg_write(CFG_STALE_CHECK_ENABLE, {15'($urandom), en});
        i_cfg_valid = 1'b0;
    endtask

    // One random event. Most traffic is well formed: a success and then failures
    // that walk the streak across the limit (a short run after the first under a
    // high limit), or mixed events on a few hot sensors; else noise on any sensor.
    task automatic random_event();
        t_action                act;
        logic [SENSOR_ID_W-1:0] id;
        logic [TIME_W-1:0]      now;
        int unsigned            pick;
        int unsigned            thr;
        int unsigned            lim;
        thr = int'(sb.stale_ms) * US_PER_MS + US_PER_MS;
        lim = int'(sb.streak_limit);
        if (fail_run > 0) begin
            act = ACT_FAILURE;
            id  = run_id;
            fail_run--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                run_id = SENSOR_ID_W'($urandom);
                id     = run_id;
                act    = ACT_SUCCESS;
                if (lim > 16 && long_done) begin
                    fail_run = $urandom_range(1, 8);
                end else begin
                    fail_run  = lim + $urandom_range(0, 2);
                    long_done = (lim > 16);
                end
            end else begin
                id = (pick < 70) ? SENSOR_ID_W'($urandom_range(0, 3)) : SENSOR_ID_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    act = ACT_SUCCESS;
                else if (pick < 75)
                    act = ACT_FAILURE;
                else if (pick < 80)
                    act = ACT_CLEAR;
                else
                    act = ACT_CHECK;
            end
        end

        // Time: small steps, steps around the stale window, jumps anywhere
        // (wrapping included), and stamps right at the stale edge.
        pick = $urandom_range(0, 99);
        if (pick < 55)
            t_base = t_base + TIME_W'($urandom_range(0, 1500));
        else if (pick < 85)
            t_base = t_base + TIME_W'($urandom_range(0, thr * 2));
        else if (pick < 92)
            t_base = TIME_W'($urandom);
        if (pick >= 92)
            now = sb.last_ok[id] + TIME_W'(thr - 1) + TIME_W'($urandom_range(0, 1));
        else
            now = t_base;
        push_event(act, id, now);
    endtask

    initial begin
        logic [STREAK_LIM_W-1:0] lim;
        logic [STALE_MS_W-1:0]   ms;
        logic                    en;
        int                      n;

        // Drive every input to a known value before the first edge.
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_action    = ACT_CHECK;
        i_sensor_id = '0;
        i_now_us    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        calm        = 1'b0;
        gap_odds    = 4;
        fail_run    = 0;
        run_id      = '0;
        long_done   = 1'b0;
        t_base      = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under the reset settings.
        push_event(ACT_CHECK,   4'd0,  32'd0);          // never read
        push_event(ACT_SUCCESS, 4'd0,  32'd0);
        push_event(ACT_CHECK,   4'd0,  32'd500_999);    // last microsecond still fresh
        push_event(ACT_CHECK,   4'd0,  32'd501_000);    // one millisecond past the limit
        push_event(ACT_FAILURE, 4'd1,  32'd100);        // failures only, timed from zero
        push_event(ACT_CHECK,   4'd1,  32'd501_000);
        repeat (5) push_event(ACT_FAILURE, 4'd2, 32'd1000);  // streak walks onto the limit
        push_event(ACT_SUCCESS, 4'd2,  32'd2000);
        push_event(ACT_CLEAR,   4'd2,  32'd3000);
        push_event(ACT_SUCCESS, 4'd15, 32'hFFFF_FF00);  // time wraps past zero
        push_event(ACT_CHECK,   4'd15, 32'h0000_0100);
        push_event(ACT_CHECK,   4'd15, 32'h7FFF_FFFF);
        push_event(ACT_SUCCESS, 4'd3,  32'hFFFF_FFFF);
        push_event(ACT_FAILURE, 4'd3,  32'hFFFF_FFFF);

        // Streak limit of zero: every sensor reports unhealthy. Also poke
        // the unused index, which must leave the settings alone.
        wait_drain();
        apply_settings(8'd0, 16'd0, 1'b1);
        cfg_write(CFG_UNUSED_IDX, '1);
        i_cfg_valid = 1'b0;
        push_event(ACT_SUCCESS, 4'd4, 32'd1000);
        push_event(ACT_CHECK,   4'd4, 32'd1999);

        // Widest streak limit with a zero stale limit: exactly at the edge.
        wait_drain();
        apply_settings(8'd255, 16'd0, 1'b1);
        push_event(ACT_CHECK, 4'd4, 32'd1999);
        push_event(ACT_CHECK, 4'd4, 32'd2000);

        // Stale check off with the widest stale limit.
        wait_drain();
        apply_settings(8'd255, 16'hFFFF, 1'b0);
        push_event(ACT_CHECK, 4'd0,  32'h8000_0000);
        push_event(ACT_CHECK, 4'd4,  32'hFFFF_FFFF);
        push_event(ACT_CLEAR, 4'd15, 32'd0);

        // Random phases, each under its own settings; the last runs calm.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin lim = 8'd1;   ms = 16'd0;     en = 1'b1; end
                1: begin lim = 8'd255; ms = 16'hFFFF;  en = 1'b1; end
                2: begin lim = 8'd3;   ms = 16'd2;     en = 1'b1; end
                3: begin lim = 8'd0;   ms = 16'd1;     en = 1'b1; end
                4: begin lim = 8'd4;   ms = 16'd0;     en = 1'b0; end
                default: begin
                    lim = STREAK_LIM_W'($urandom_range(1, 8));
                    ms  = STALE_MS_W'($urandom_range(0, 4));
                    en  = 1'($urandom_range(0, 1));
                end
            endcase
            wait_drain();
            apply_settings(lim, ms, en);
            fail_run  = 0;
            long_done = 1'b0;
            if (p == 7)
                calm = 1'b1;
            n = 0;
            while (n < ITEMS_PER_PHASE || fail_run > 0) begin
                // Reshape the sender's idling every few dozen items.
                if (n % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       gap_odds = 0;
                        1:       gap_odds = 3;
                        default: gap_odds = 10;
                    endcase
                end
                random_event();
                n++;
            end
        end

        // Let the last results come, then leave room for any stray one.
        wait_drain();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
